// ===== src/clr_pkg.sv =====
// clr_pkg: shared constants and types for the clipped line rasterizer
// no dependencies; used by every module in src
package clr_pkg;

  localparam int COORD_BITS_DEFAULT = 13;
  localparam int DIM_BITS           = 12;
  localparam int OFFSET_BITS        = 24;
  localparam int ADDR_BITS          = 26;
  localparam int COLOR_BITS         = 8;
  localparam int PITCH_BITS         = DIM_BITS + 1;
  localparam int PADDR_BITS         = 4;
  localparam int PDATA_BITS         = 32;

  // opcodes carried on the input tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // register byte addresses
  localparam logic [PADDR_BITS-1:0] ADDR_VIEW_WIDTH  = 4'h0;
  localparam logic [PADDR_BITS-1:0] ADDR_VIEW_HEIGHT = 4'h4;
  localparam logic [PADDR_BITS-1:0] ADDR_ROW_EXTRA   = 4'h8;
  localparam logic [PADDR_BITS-1:0] ADDR_VIEW_OFFSET = 4'hC;

  localparam logic [DIM_BITS-1:0]    RST_VIEW_WIDTH  = 12'd320;
  localparam logic [DIM_BITS-1:0]    RST_VIEW_HEIGHT = 12'd200;
  localparam logic [DIM_BITS-1:0]    RST_ROW_EXTRA   = 12'd0;
  localparam logic [OFFSET_BITS-1:0] RST_VIEW_OFFSET = 24'd0;

  typedef struct packed {
    logic [DIM_BITS-1:0]    view_width;
    logic [DIM_BITS-1:0]    view_height;
    logic [DIM_BITS-1:0]    row_extra;
    logic [OFFSET_BITS-1:0] view_offset;
  } cfg_t;

endpackage

// ===== src/clr_regs.sv =====
// clr_regs: register bank behind the configuration port
// depends on clr_pkg
module clr_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [clr_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [clr_pkg::PDATA_BITS-1:0]     pwdata,
  output logic [clr_pkg::PDATA_BITS-1:0]     prdata,
  output logic                               pready,
  output clr_pkg::cfg_t                      cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.view_width  <= clr_pkg::RST_VIEW_WIDTH;
      cfg.view_height <= clr_pkg::RST_VIEW_HEIGHT;
      cfg.row_extra   <= clr_pkg::RST_ROW_EXTRA;
      cfg.view_offset <= clr_pkg::RST_VIEW_OFFSET;
    end else if (wr) begin
      unique case (paddr)
        clr_pkg::ADDR_VIEW_WIDTH:  cfg.view_width  <= pwdata[clr_pkg::DIM_BITS-1:0];
        clr_pkg::ADDR_VIEW_HEIGHT: cfg.view_height <= pwdata[clr_pkg::DIM_BITS-1:0];
        clr_pkg::ADDR_ROW_EXTRA:   cfg.row_extra   <= pwdata[clr_pkg::DIM_BITS-1:0];
        clr_pkg::ADDR_VIEW_OFFSET: cfg.view_offset <= pwdata[clr_pkg::OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      clr_pkg::ADDR_VIEW_WIDTH:  prdata = clr_pkg::PDATA_BITS'(cfg.view_width);
      clr_pkg::ADDR_VIEW_HEIGHT: prdata = clr_pkg::PDATA_BITS'(cfg.view_height);
      clr_pkg::ADDR_ROW_EXTRA:   prdata = clr_pkg::PDATA_BITS'(cfg.row_extra);
      clr_pkg::ADDR_VIEW_OFFSET: prdata = clr_pkg::PDATA_BITS'(cfg.view_offset);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== src/clr_stepper.sv =====
// clr_stepper: line state and one error-driven step per transaction
// depends on clr_pkg; feeds clr_address through a one-entry pixel register
module clr_stepper #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [COORD_BITS-1:0]           in_x_start,
  input  logic [COORD_BITS-1:0]           in_y_start,
  input  logic [COORD_BITS-1:0]           in_x_end,
  input  logic [COORD_BITS-1:0]           in_y_end,
  input  logic [clr_pkg::COLOR_BITS-1:0]  in_color,
  input  logic                            take,
  output logic                            pix_valid,
  output logic [COORD_BITS-1:0]           pix_x,
  output logic [COORD_BITS-1:0]           pix_y,
  output logic [clr_pkg::COLOR_BITS-1:0]  pix_color,
  output logic                            pix_last
);

  localparam int DW = COORD_BITS + 1;   // absolute delta
  localparam int EW = COORD_BITS + 3;   // error term

  logic [COORD_BITS-1:0]          cur_x, cur_y, end_x, end_y;
  logic [DW-1:0]                  delta_x, delta_y;
  logic                           step_x_neg, step_y_neg;
  logic signed [EW-1:0]           error_term;
  logic [clr_pkg::COLOR_BITS-1:0] line_color;
  logic                           active;

  logic [COORD_BITS-1:0]          cur_x_next, cur_y_next, end_x_next, end_y_next;
  logic [DW-1:0]                  delta_x_next, delta_y_next;
  logic                           step_x_neg_next, step_y_neg_next;
  logic signed [EW-1:0]           error_term_next;
  logic [clr_pkg::COLOR_BITS-1:0] line_color_next;
  logic                           produce, fin, fire;

  logic signed [DW-1:0]           w, h;
  logic signed [EW-1:0]           dx_s, dy_s;
  logic                           move_x, move_y;

  assign in_ready = !pix_valid || take;
  assign fire     = in_valid && in_ready;

  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    end_x_next      = end_x;
    end_y_next      = end_y;
    delta_x_next    = delta_x;
    delta_y_next    = delta_y;
    step_x_neg_next = step_x_neg;
    step_y_neg_next = step_y_neg;
    error_term_next = error_term;
    line_color_next = line_color;
    produce         = 1'b0;
    w      = $signed({in_x_end[COORD_BITS-1], in_x_end})
           - $signed({in_x_start[COORD_BITS-1], in_x_start});
    h      = $signed({in_y_end[COORD_BITS-1], in_y_end})
           - $signed({in_y_start[COORD_BITS-1], in_y_start});
    dx_s   = $signed({2'b00, delta_x});
    dy_s   = $signed({2'b00, delta_y});
    move_x = error_term > -dx_s;
    move_y = error_term < dy_s;
    if (in_opcode == clr_pkg::OP_START) begin
      produce         = 1'b1;
      cur_x_next      = in_x_start;
      cur_y_next      = in_y_start;
      end_x_next      = in_x_end;
      end_y_next      = in_y_end;
      line_color_next = in_color;
      step_x_neg_next = w[DW-1];
      step_y_neg_next = h[DW-1];
      delta_x_next    = w[DW-1] ? DW'(-w) : DW'(w);
      delta_y_next    = h[DW-1] ? DW'(-h) : DW'(h);
      // half of the major delta, toward zero
      if (delta_x_next > delta_y_next)
        error_term_next = $signed(EW'(delta_x_next >> 1));
      else
        error_term_next = -$signed(EW'(delta_y_next >> 1));
    end else if (active) begin
      produce = 1'b1;
      if (move_x) begin
        cur_x_next = step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        cur_y_next = step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      error_term_next = error_term - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
    end
    fin = (cur_x_next == end_x_next) && (cur_y_next == end_y_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid  <= 1'b0;
      active     <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      end_x      <= '0;
      end_y      <= '0;
      delta_x    <= '0;
      delta_y    <= '0;
      step_x_neg <= 1'b0;
      step_y_neg <= 1'b0;
      error_term <= '0;
      line_color <= '0;
    end else if (fire) begin
      pix_valid  <= produce;
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      end_x      <= end_x_next;
      end_y      <= end_y_next;
      delta_x    <= delta_x_next;
      delta_y    <= delta_y_next;
      step_x_neg <= step_x_neg_next;
      step_y_neg <= step_y_neg_next;
      error_term <= error_term_next;
      line_color <= line_color_next;
      if (produce) begin
        active <= !fin;
      end
    end else if (take) begin
      pix_valid <= 1'b0;
    end
  end

  // pixel payload follows the state that was just written
  always_ff @(posedge clk) begin
    if (fire && produce) begin
      pix_x     <= cur_x_next;
      pix_y     <= cur_y_next;
      pix_color <= line_color_next;
      pix_last  <= fin;
    end
  end

endmodule

// ===== src/clr_address.sv =====
// clr_address: clip test, frame-buffer address and output register
// depends on clr_pkg; takes pixels from clr_stepper
module clr_address #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  clr_pkg::cfg_t                   cfg,
  input  logic                            pix_valid,
  input  logic [COORD_BITS-1:0]           pix_x,
  input  logic [COORD_BITS-1:0]           pix_y,
  input  logic [clr_pkg::COLOR_BITS-1:0]  pix_color,
  input  logic                            pix_last,
  output logic                            take,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [COORD_BITS-1:0]           out_x,
  output logic [COORD_BITS-1:0]           out_y,
  output logic                            out_we,
  output logic [clr_pkg::ADDR_BITS-1:0]   out_addr,
  output logic [clr_pkg::COLOR_BITS-1:0]  out_color,
  output logic                            out_last
);

  localparam int CW = (COORD_BITS > clr_pkg::DIM_BITS) ? COORD_BITS : clr_pkg::DIM_BITS;
  localparam int PW = clr_pkg::DIM_BITS + clr_pkg::PITCH_BITS;

  logic [CW-1:0]                     x_mag, y_mag;
  logic                              in_view;
  logic [clr_pkg::PITCH_BITS-1:0]    pitch;
  logic [PW-1:0]                     row_base;
  logic [clr_pkg::ADDR_BITS-1:0]     addr;

  assign take = !out_valid || out_ready;

  always_comb begin
    x_mag   = CW'(pix_x);
    y_mag   = CW'(pix_y);
    in_view = !pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1]
            && (x_mag < CW'(cfg.view_width)) && (y_mag < CW'(cfg.view_height));
    pitch    = clr_pkg::PITCH_BITS'(cfg.view_width) + clr_pkg::PITCH_BITS'(cfg.row_extra);
    // inside the view y is below 4096, so twelve bits carry it
    row_base = clr_pkg::DIM_BITS'(y_mag) * pitch;
    addr     = clr_pkg::ADDR_BITS'(cfg.view_offset) + clr_pkg::ADDR_BITS'(row_base)
             + clr_pkg::ADDR_BITS'(clr_pkg::DIM_BITS'(x_mag));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && pix_valid) begin
      out_x     <= pix_x;
      out_y     <= pix_y;
      out_we    <= in_view;
      out_addr  <= in_view ? addr : '0;
      out_color <= pix_color;
      out_last  <= pix_last;
    end
  end

endmodule

// ===== src/clipped_line_rasterizer.sv =====
// clipped_line_rasterizer: line rasterizer with per-pixel view clipping
// depends on clr_pkg, clr_regs, clr_stepper, clr_address
// pipeline: stepper pixel register, then address multiply and output register
// throughput: one transaction per cycle, start or step, unless the output stalls;
//   the step's error add and compare close in the cycle that accepts it
// reset: synchronous rst clears the pipeline, ends any line, loads register defaults
module clipped_line_rasterizer #(
  parameter int COORD_BITS = clr_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // x_start, y_start, x_end, y_end, pen_color, zero pad
  input  logic [((4*COORD_BITS+clr_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic                                s_axis_tuser,
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pixel_x, pixel_y, buffer_address, pixel_color, zero pad
  output logic [((2*COORD_BITS+clr_pkg::ADDR_BITS+clr_pkg::COLOR_BITS+7)/8)*8-1:0]
                                              m_axis_tdata,
  // write_enable
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [clr_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [clr_pkg::PDATA_BITS-1:0]      pwdata,
  output logic [clr_pkg::PDATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam int CB       = COORD_BITS;
  localparam int OUT_BITS = 2*CB + clr_pkg::ADDR_BITS + clr_pkg::COLOR_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  clr_pkg::cfg_t                  cfg;
  logic                           take, pix_valid, pix_last;
  logic [CB-1:0]                  pix_x, pix_y, out_x, out_y;
  logic [clr_pkg::COLOR_BITS-1:0] pix_color, out_color;
  logic [clr_pkg::ADDR_BITS-1:0]  out_addr;
  logic [OUT_BITS-1:0]            out_packed;

  clr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clr_stepper #(.COORD_BITS(CB)) u_stepper (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_opcode  (s_axis_tuser),
    .in_x_start (s_axis_tdata[CB-1:0]),
    .in_y_start (s_axis_tdata[2*CB-1:CB]),
    .in_x_end   (s_axis_tdata[3*CB-1:2*CB]),
    .in_y_end   (s_axis_tdata[4*CB-1:3*CB]),
    .in_color   (s_axis_tdata[4*CB+clr_pkg::COLOR_BITS-1:4*CB]),
    .take       (take),
    .pix_valid  (pix_valid),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_color  (pix_color),
    .pix_last   (pix_last)
  );

  clr_address #(.COORD_BITS(CB)) u_address (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_x     (pix_x),
    .pix_y     (pix_y),
    .pix_color (pix_color),
    .pix_last  (pix_last),
    .take      (take),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_we    (m_axis_tuser),
    .out_addr  (out_addr),
    .out_color (out_color),
    .out_last  (m_axis_tlast)
  );

  assign out_packed   = {out_color, out_addr, out_y, out_x};
  assign m_axis_tdata = OUT_W'(out_packed);

endmodule
